/* src/feedback_delay_line_defines.svh */
// ----------------------------------------------------------------------------
// feedback delay line assertion macros
// shared concurrent assertion forms, reset disables every check
// ----------------------------------------------------------------------------
`ifndef FEEDBACK_DELAY_LINE_DEFINES_SVH
`define FEEDBACK_DELAY_LINE_DEFINES_SVH

// same-cycle implication
`define FDL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FDL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/fdl_pkg.sv */
// ----------------------------------------------------------------------------
// fdl_pkg
// widths, register indexes and fixed-point helpers of the feedback delay line
// ----------------------------------------------------------------------------
`default_nettype none

package fdl_pkg;

    localparam int SAMPLE_W            = 16;
    localparam int STORE_W             = 20;
    localparam int GAIN_W              = 15;
    localparam int LEN_W               = 13;
    localparam int CFG_DATA_W          = 15;
    localparam int CFG_IDX_W           = 2;
    localparam int Q_SHIFT             = 15;
    localparam int DEFAULT_DELAY_DEPTH = 4096;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN   = 2'd2;

    localparam logic [GAIN_W-1:0] FEEDBACK_GAIN_RESET = 15'd0;
    localparam logic [GAIN_W-1:0] OUTPUT_GAIN_RESET   = 15'd32767;

    localparam logic signed [STORE_W-1:0] STORE_MAX = 20'sh7FFFF;
    localparam logic signed [STORE_W-1:0] STORE_MIN = 20'sh80000;

    // clamp a 21-bit sum to the 20-bit store range
    function automatic logic signed [STORE_W-1:0] sat_sum(input logic signed [STORE_W:0] s);
        logic signed [STORE_W-1:0] r;
        if (s > $signed({STORE_MAX[STORE_W-1], STORE_MAX})) begin
            r = STORE_MAX;
        end else if (s < $signed({STORE_MIN[STORE_W-1], STORE_MIN})) begin
            r = STORE_MIN;
        end else begin
            r = s[STORE_W-1:0];
        end
        return r;
    endfunction

    // floor(v * g / 2^15), arithmetic shift rounds toward minus infinity
    function automatic logic signed [STORE_W-1:0] scale_q15(
        input logic signed [STORE_W-1:0] v,
        input logic        [GAIN_W-1:0]  g
    );
        logic signed [STORE_W+GAIN_W:0] p;
        p = v * $signed({1'b0, g});
        return p[Q_SHIFT+STORE_W-1:Q_SHIFT];
    endfunction

endpackage

`default_nettype wire

/* src/feedback_delay_line.sv */
// ----------------------------------------------------------------------------
// feedback_delay_line
// feedback comb delay: sample plus stored word, saturated, scaled back and out
// ----------------------------------------------------------------------------
// One signed 16-bit sample per word enters; it is added to the delay word at
// the cursor, the sum saturates to 20 bits, sum*feedback>>15 goes back to the
// same word and sum*output_gain>>15 leaves as the result word. The block takes
// one word per clock while its output register is free or taken, and its
// result word is offered after the memory read on the acceptance edge, the
// sum stage and the scale stage into the output register. The delay memory
// has one read port and one write port, and the loop from the feedback
// multiplier back into the sum adder is closed by forwarding, so a delay of
// one sample still runs at full rate. A full output register that is not
// taken holds the whole pipeline. Memory words that were never written read
// as zero through a fill mark, so no clearing pass follows reset and the
// block is ready at once. The user must write configuration only while the
// block is idle; the block itself does not enforce it. A delay length of zero
// acts as one and lengths above the memory depth are clipped to it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "feedback_delay_line_defines.svh"

module feedback_delay_line #(
    parameter int DELAY_DEPTH = fdl_pkg::DEFAULT_DELAY_DEPTH
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // sample input
    input  wire logic                                  i_in_valid,
    output      logic                                  o_in_ready,
    input  wire logic signed [fdl_pkg::SAMPLE_W-1:0]   i_sample_in,
    // result output
    output      logic                                  o_out_valid,
    input  wire logic                                  i_out_ready,
    output      logic signed [fdl_pkg::STORE_W-1:0]    o_sample_out,
    // configuration writes
    input  wire logic                                  i_cfg_valid,
    output      logic                                  o_cfg_ready,
    input  wire logic [fdl_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [fdl_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import fdl_pkg::*;

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int FW = AW + 1;                        // holds the depth itself
    localparam int CW = (FW > LEN_W) ? FW : LEN_W;     // length compare width

    // configuration
    logic [FW-1:0]     r_eff_len;
    logic [GAIN_W-1:0] r_fb_gain;
    logic [GAIN_W-1:0] r_out_gain;
    logic [CW-1:0]     cfg_len_wide;
    logic [FW-1:0]     n_eff_len;

    // cursor and fill mark
    logic [AW-1:0] r_cursor;
    logic [AW-1:0] n_cursor;
    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;
    logic [FW-1:0] cursor_inc;

    // sum stage
    logic                      r_s1_valid;
    logic [AW-1:0]             r_s1_idx;
    logic signed [SAMPLE_W-1:0] r_s1_sample;
    logic                      r_s1_written;
    logic                      r_cap_hit;
    logic signed [STORE_W-1:0] r_cap_data;
    logic signed [STORE_W-1:0] rd_data;
    logic signed [STORE_W-1:0] old_word;
    logic signed [STORE_W-1:0] s1_sum;
    logic                      live_hit;

    // scale stage
    logic                      r_s2_valid;
    logic [AW-1:0]             r_s2_idx;
    logic signed [STORE_W-1:0] r_s2_sum;
    logic signed [STORE_W-1:0] s2_fb_word;
    logic signed [STORE_W-1:0] s2_out_word;

    // output register
    logic                      r_out_valid;
    logic signed [STORE_W-1:0] r_out_word;

    logic advance;
    logic in_accept;
    logic s2_write;

    // whole pipeline moves unless a result sits untaken
    assign advance     = !r_out_valid || i_out_ready;
    assign o_in_ready  = advance;
    assign in_accept   = i_in_valid && advance;
    assign s2_write    = r_s2_valid && advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_sample_out = r_out_word;

    // ---------------------------------------------------------------- config
    always_comb begin
        cfg_len_wide = CW'(i_cfg_data[LEN_W-1:0]);
        if (cfg_len_wide == '0) begin
            n_eff_len = FW'(1);
        end else if (cfg_len_wide > CW'(DELAY_DEPTH)) begin
            n_eff_len = FW'(DELAY_DEPTH);
        end else begin
            n_eff_len = cfg_len_wide[FW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_len  <= FW'(1);
            r_fb_gain  <= FEEDBACK_GAIN_RESET;
            r_out_gain <= OUTPUT_GAIN_RESET;
        end else if (i_cfg_valid) begin
            // indexes beyond the list are dropped
            unique case (i_cfg_index)
                CFG_DELAY_LENGTH:  r_eff_len  <= n_eff_len;
                CFG_FEEDBACK_GAIN: r_fb_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_OUTPUT_GAIN:   r_out_gain <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------ cursor and fill
    // the cursor only steps by one or returns to zero, so the written words
    // always form a prefix of the memory and one fill mark says which are live
    always_comb begin
        cursor_inc = {1'b0, r_cursor} + FW'(1);
        n_cursor   = (cursor_inc >= r_eff_len) ? '0 : cursor_inc[AW-1:0];
        n_fill     = r_fill;
        if (s2_write && ({1'b0, r_s2_idx} == r_fill)) begin
            n_fill = r_fill + FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_fill   <= '0;
        end else begin
            if (in_accept) begin
                r_cursor <= n_cursor;
            end
            r_fill <= n_fill;
        end
    end

    // ---------------------------------------------------------------- memory
    fdl_store #(
        .DEPTH (DELAY_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (in_accept),
        .i_rd_addr (r_cursor),
        .o_rd_data (rd_data),
        .i_wr_en   (s2_write),
        .i_wr_addr (r_s2_idx),
        .i_wr_data (s2_fb_word)
    );

    // ------------------------------------------------------------- sum stage
    // newest pending write to the same word wins: the word now in the scale
    // stage, then the one written on the acceptance edge, then the memory
    always_comb begin
        live_hit = r_s2_valid && (r_s2_idx == r_s1_idx);
        priority if (live_hit) begin
            old_word = s2_fb_word;
        end else if (r_cap_hit) begin
            old_word = r_cap_data;
        end else if (r_s1_written) begin
            old_word = rd_data;
        end else begin
            old_word = '0;
        end
        s1_sum = sat_sum({{(STORE_W+1-SAMPLE_W){r_s1_sample[SAMPLE_W-1]}}, r_s1_sample}
                         + {old_word[STORE_W-1], old_word});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_idx     <= r_cursor;
            r_s1_sample  <= i_sample_in;
            r_s1_written <= ({1'b0, r_cursor} < r_fill);
            r_cap_hit    <= r_s2_valid && (r_s2_idx == r_cursor);
            r_cap_data   <= s2_fb_word;
        end
    end

    // ----------------------------------------------------------- scale stage
    assign s2_fb_word  = scale_q15(r_s2_sum, r_fb_gain);
    assign s2_out_word = scale_q15(r_s2_sum, r_out_gain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (advance) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_s2_idx <= r_s1_idx;
            r_s2_sum <= s1_sum;
        end
    end

    // ------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_write) begin
            r_out_word <= s2_out_word;
        end
    end

    // ------------------------------------------------------------ assertions
    `FDL_ASSERT_NOW(a_write_within_prefix, i_clk, i_rst_n, s2_write, ({1'b0, r_s2_idx} <= r_fill), "delay word written beyond the fill mark")
    `FDL_ASSERT_NEXT(a_stall_holds_pipe, i_clk, i_rst_n, r_out_valid && !i_out_ready, (r_s2_valid == $past(r_s2_valid)) && (r_s1_valid == $past(r_s1_valid)), "pipeline moved while the output word was held")
    `FDL_ASSERT_NEXT(a_unit_delay_cursor, i_clk, i_rst_n, in_accept && (r_eff_len == FW'(1)), (r_cursor == '0), "cursor left zero with a one-sample delay")

endmodule

`default_nettype wire

/* src/fdl_store.sv */
// ----------------------------------------------------------------------------
// fdl_store
// delay word memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module fdl_store #(
    parameter int DEPTH = fdl_pkg::DEFAULT_DELAY_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rd_en,
    input  wire logic [AW-1:0]                      i_rd_addr,
    output      logic signed [fdl_pkg::STORE_W-1:0] o_rd_data,
    input  wire logic                               i_wr_en,
    input  wire logic [AW-1:0]                      i_wr_addr,
    input  wire logic signed [fdl_pkg::STORE_W-1:0] i_wr_data
);
    import fdl_pkg::*;

    logic signed [STORE_W-1:0] r_mem [DEPTH];

    // read returns the word held before a same-edge write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire
